// ----- src/assert_macros.svh -----
// assertion macros included by the solver rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, gated by reset
`define QRS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, gated by reset
`define QRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/qrs_pkg.sv -----
// types and constants of the quadratic root solver
package qrs_pkg;

    localparam int EPS_W = 17;
    localparam logic [EPS_W-1:0] EPS_RESET = 17'd1;

    // root count codes
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_ALL  = 2'd3;

    typedef struct packed {
        logic signed [31:0] coef_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] coef_c;
    } in_t;

    typedef struct packed {
        logic [1:0]         root_count;
        logic signed [31:0] root_one;
        logic signed [31:0] root_two;
        logic               saturated;
    } out_t;

endpackage

// ----- src/qrs_sqrt_pipe.sv -----
// pipelined integer square root, one root bit per stage
module qrs_sqrt_pipe #(
    parameter int ROOT_W = 24,
    parameter int TAG_W  = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   rad,
    input  logic [TAG_W-1:0]      in_tag,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     root,
    output logic [TAG_W-1:0]      out_tag
);
    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 1;

    logic              vld_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [TAG_W-1:0]  tag_reg  [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_step
        logic              vld_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        logic [TAG_W-1:0]  tag_in;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  diff;
        logic              take;

        if (i == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
            assign tag_in  = in_tag;
        end else begin : g_later
            assign vld_in  = vld_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rad_in  = rad_reg[i-1];
            assign tag_in  = tag_reg[i-1];
        end

        // bring down two radicand bits and try the next root bit
        assign rem_sh = {rem_in, rad_in[RAD_W-1 -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};
        assign take   = rem_sh >= trial;
        assign diff   = rem_sh - trial;

        always_ff @(posedge clk) begin
            if (!rst_n) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[i]  <= take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
                root_reg[i] <= {root_in[ROOT_W-2:0], take};
                rad_reg[i]  <= {rad_in[RAD_W-3:0], 2'b00};
                tag_reg[i]  <= tag_in;
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_tag   = tag_reg[ROOT_W-1];

endmodule

// ----- src/qrs_div_pipe.sv -----
// pipelined restoring divider on magnitudes, one quotient bit per stage
module qrs_div_pipe #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 33,
    parameter int TAG_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_valid,
    output logic [NUM_W-1:0]  quo,
    output logic [TAG_W-1:0]  out_tag
);
    logic             vld_reg [NUM_W];
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] quo_reg [NUM_W];
    logic [NUM_W-1:0] num_reg [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [TAG_W-1:0] tag_reg [NUM_W];

    for (genvar i = 0; i < NUM_W; i++) begin : g_step
        logic             vld_in;
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] quo_in;
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] den_in;
        logic [TAG_W-1:0] tag_in;
        logic [DEN_W:0]   rem_sh;
        logic [DEN_W:0]   diff;
        logic             take;

        if (i == 0) begin : g_first
            assign vld_in = in_valid;
            assign rem_in = '0;
            assign quo_in = '0;
            assign num_in = num;
            assign den_in = den;
            assign tag_in = in_tag;
        end else begin : g_later
            assign vld_in = vld_reg[i-1];
            assign rem_in = rem_reg[i-1];
            assign quo_in = quo_reg[i-1];
            assign num_in = num_reg[i-1];
            assign den_in = den_reg[i-1];
            assign tag_in = tag_reg[i-1];
        end

        // shift in the next dividend bit and subtract if it fits
        assign rem_sh = {rem_in, num_in[NUM_W-1]};
        assign take   = rem_sh >= {1'b0, den_in};
        assign diff   = rem_sh - {1'b0, den_in};

        always_ff @(posedge clk) begin
            if (!rst_n) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk) begin
            if (en) begin
                rem_reg[i] <= take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                quo_reg[i] <= {quo_in[NUM_W-2:0], take};
                num_reg[i] <= {num_in[NUM_W-2:0], 1'b0};
                den_reg[i] <= den_in;
                tag_reg[i] <= tag_in;
            end
        end
    end

    assign out_valid = vld_reg[NUM_W-1];
    assign quo       = quo_reg[NUM_W-1];
    assign out_tag   = tag_reg[NUM_W-1];

endmodule

// ----- src/quadratic_root_solver.sv -----
// throughput: one request per cycle while results are taken; four front
// stages, a square-root pipeline of one root bit per stage, a numerator
// stage, two dividers of one quotient bit per stage and an output register
// set the depth
// reset: synchronous active-low aresetn clears all valid bits, epsilon to 1
// when the result is not taken the whole pipeline holds and s_ready drops
`include "assert_macros.svh"

module quadratic_root_solver #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  qrs_pkg::in_t                 s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output qrs_pkg::out_t                m_data,
    input  logic                         cfg_we,
    input  logic [qrs_pkg::EPS_W-1:0]    cfg_wdata
);
    localparam int SQ_H     = (32 + FRAC_BITS) / 2;
    localparam int SQ_RAD_W = 2 * SQ_H;
    localparam int MAG_W    = 33;
    localparam int DIV_NW   = MAG_W + FRAC_BITS;

    typedef struct packed {
        logic [1:0]         count;
        logic               sat;
        logic               r1_zero;
        logic               two;
        logic signed [32:0] num;
        logic signed [32:0] den;
    } sq_tag_t;

    typedef struct packed {
        logic [1:0] count;
        logic       sat;
        logic       r1_zero;
        logic       two;
        logic       neg;
    } dv_tag_t;

    localparam int SQ_TAG_W = $bits(sq_tag_t);
    localparam int DV_TAG_W = $bits(dv_tag_t);

    function automatic logic near_zero(input logic signed [31:0] v,
                                       input logic [qrs_pkg::EPS_W-1:0] e);
        logic [32:0] mag;
        mag = v[31] ? (33'd0 - {v[31], v}) : {1'b0, v};
        return mag < {16'd0, e};
    endfunction

    // returns {saturated, value} of a signed quotient given as magnitude and sign
    function automatic logic [32:0] clip_root(input logic [DIV_NW-1:0] q,
                                              input logic neg);
        logic [DIV_NW-1:0] lim;
        logic [31:0]       val;
        logic              sat;
        lim = neg ? DIV_NW'(33'h080000000) : DIV_NW'(32'h7FFFFFFF);
        sat = q > lim;
        if (sat) begin
            val = neg ? 32'h80000000 : 32'h7FFFFFFF;
        end else begin
            val = neg ? (32'd0 - q[31:0]) : q[31:0];
        end
        return {sat, val};
    endfunction

    logic pipe_en;

    // epsilon register
    logic [qrs_pkg::EPS_W-1:0] eps_reg;
    logic [qrs_pkg::EPS_W-1:0] eps_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= qrs_pkg::EPS_RESET;
        end else if (cfg_we) begin
            eps_reg <= cfg_wdata;
        end
    end

    assign eps_eff = (eps_reg == '0) ? qrs_pkg::EPS_RESET : eps_reg;

    // stage 1: capture coefficients and zero tests
    logic               p1_vld_reg;
    logic signed [31:0] p1_a_reg, p1_b_reg, p1_c_reg;
    logic               p1_za_reg, p1_zb_reg, p1_zc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            p1_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p1_a_reg  <= s_data.coef_a;
            p1_b_reg  <= s_data.coef_b;
            p1_c_reg  <= s_data.coef_c;
            p1_za_reg <= near_zero(s_data.coef_a, eps_eff);
            p1_zb_reg <= near_zero(s_data.coef_b, eps_eff);
            p1_zc_reg <= near_zero(s_data.coef_c, eps_eff);
        end
    end

    // stage 2: products b*b and a*c
    logic               p2_vld_reg;
    logic signed [63:0] p2_bb_reg, p2_ac_reg;
    logic signed [31:0] p2_a_reg, p2_b_reg, p2_c_reg;
    logic               p2_za_reg, p2_zb_reg, p2_zc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p2_bb_reg <= 64'(p1_b_reg) * 64'(p1_b_reg);
            p2_ac_reg <= 64'(p1_a_reg) * 64'(p1_c_reg);
            p2_a_reg  <= p1_a_reg;
            p2_b_reg  <= p1_b_reg;
            p2_c_reg  <= p1_c_reg;
            p2_za_reg <= p1_za_reg;
            p2_zb_reg <= p1_zb_reg;
            p2_zc_reg <= p1_zc_reg;
        end
    end

    // stage 3: quarter discriminant b*b/4 - a*c
    logic               p3_vld_reg;
    logic signed [63:0] p3_u_reg;
    logic signed [63:0] u_next;
    logic signed [31:0] p3_a_reg, p3_b_reg, p3_c_reg;
    logic               p3_za_reg, p3_zb_reg, p3_zc_reg;

    assign u_next = $signed({2'b00, p2_bb_reg[63:2]}) - p2_ac_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p3_u_reg  <= u_next;
            p3_a_reg  <= p2_a_reg;
            p3_b_reg  <= p2_b_reg;
            p3_c_reg  <= p2_c_reg;
            p3_za_reg <= p2_za_reg;
            p3_zb_reg <= p2_zb_reg;
            p3_zc_reg <= p2_zc_reg;
        end
    end

    // stage 4: rescale discriminant with floor and clip to 32 bits
    logic               p4_vld_reg;
    logic signed [31:0] p4_d_reg;
    logic               p4_dsat_reg;
    logic signed [31:0] p4_a_reg, p4_b_reg, p4_c_reg;
    logic               p4_za_reg, p4_zb_reg, p4_zc_reg;
    logic signed [63:0] d_full;
    logic               d_hi, d_lo;
    logic signed [31:0] d_next;

    assign d_full = p3_u_reg >>> (FRAC_BITS - 2);
    assign d_hi   = d_full > 64'sh000000007FFFFFFF;
    assign d_lo   = d_full < 64'shFFFFFFFF80000000;
    assign d_next = d_hi ? 32'sh7FFFFFFF : (d_lo ? 32'sh80000000 : d_full[31:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            p4_vld_reg <= p3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p4_d_reg    <= d_next;
            p4_dsat_reg <= d_hi | d_lo;
            p4_a_reg    <= p3_a_reg;
            p4_b_reg    <= p3_b_reg;
            p4_c_reg    <= p3_c_reg;
            p4_za_reg   <= p3_za_reg;
            p4_zb_reg   <= p3_zb_reg;
            p4_zc_reg   <= p3_zc_reg;
        end
    end

    // stage 5: classify the case and set up square root and division operands
    sq_tag_t               sq_in_tag;
    logic [SQ_RAD_W-1:0]   sq_rad;
    logic                  zd;

    always_comb begin
        zd                = near_zero(p4_d_reg, eps_eff);
        sq_in_tag.count   = qrs_pkg::CNT_NONE;
        sq_in_tag.sat     = 1'b0;
        sq_in_tag.r1_zero = 1'b1;
        sq_in_tag.two     = 1'b0;
        sq_in_tag.num     = 33'sd0 - {p4_b_reg[31], p4_b_reg};
        sq_in_tag.den     = {p4_a_reg, 1'b0};
        sq_rad            = '0;
        if (p4_za_reg) begin
            // linear equation b*x + c = 0
            if (p4_zb_reg) begin
                sq_in_tag.count = p4_zc_reg ? qrs_pkg::CNT_ALL : qrs_pkg::CNT_NONE;
            end else begin
                sq_in_tag.count   = qrs_pkg::CNT_ONE;
                sq_in_tag.r1_zero = p4_zc_reg;
                sq_in_tag.num     = 33'sd0 - {p4_c_reg[31], p4_c_reg};
                sq_in_tag.den     = {p4_b_reg[31], p4_b_reg};
            end
        end else begin
            sq_in_tag.sat = p4_dsat_reg;
            if (zd) begin
                sq_in_tag.count   = qrs_pkg::CNT_ONE;
                sq_in_tag.r1_zero = 1'b0;
            end else if (p4_d_reg[31]) begin
                sq_in_tag.count = qrs_pkg::CNT_NONE;
            end else begin
                sq_in_tag.count   = qrs_pkg::CNT_TWO;
                sq_in_tag.r1_zero = 1'b0;
                sq_in_tag.two     = 1'b1;
                sq_rad            = SQ_RAD_W'({p4_d_reg[30:0], {FRAC_BITS{1'b0}}});
            end
        end
    end

    logic                sq_out_vld;
    logic [SQ_H-1:0]     sq_root;
    logic [SQ_TAG_W-1:0] sq_out_bits;
    sq_tag_t             sq_out_tag;

    qrs_sqrt_pipe #(
        .ROOT_W (SQ_H),
        .TAG_W  (SQ_TAG_W)
    ) u_sqrt (
        .clk       (aclk),
        .rst_n     (aresetn),
        .en        (pipe_en),
        .in_valid  (p4_vld_reg),
        .rad       (sq_rad),
        .in_tag    (sq_in_tag),
        .out_valid (sq_out_vld),
        .root      (sq_root),
        .out_tag   (sq_out_bits)
    );

    assign sq_out_tag = sq_out_bits;

    // stage 6: numerators -b +/- sqrt(d) (or -c for a linear equation), then magnitudes and quotient signs
    logic               p6_vld_reg;
    logic [MAG_W-1:0]   p6_mag1_reg, p6_mag2_reg, p6_dmag_reg;
    dv_tag_t            p6_tag_reg;
    logic               p6_neg2_reg;
    logic signed [33:0] n1, n2, n1_neg, n2_neg;
    logic signed [32:0] den_neg;
    dv_tag_t            dv_tag_next;

    assign n1      = {sq_out_tag.num[32], sq_out_tag.num} + $signed(34'(sq_root));
    assign n2      = {sq_out_tag.num[32], sq_out_tag.num} - $signed(34'(sq_root));
    assign n1_neg  = 34'sd0 - n1;
    assign n2_neg  = 34'sd0 - n2;
    assign den_neg = 33'sd0 - sq_out_tag.den;

    always_comb begin
        dv_tag_next.count   = sq_out_tag.count;
        dv_tag_next.sat     = sq_out_tag.sat;
        dv_tag_next.r1_zero = sq_out_tag.r1_zero;
        dv_tag_next.two     = sq_out_tag.two;
        dv_tag_next.neg     = n1[33] ^ sq_out_tag.den[32];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p6_vld_reg <= 1'b0;
        end else if (pipe_en) begin
            p6_vld_reg <= sq_out_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p6_mag1_reg <= n1[33] ? n1_neg[32:0] : n1[32:0];
            p6_mag2_reg <= n2[33] ? n2_neg[32:0] : n2[32:0];
            p6_dmag_reg <= sq_out_tag.den[32] ? den_neg : sq_out_tag.den;
            p6_tag_reg  <= dv_tag_next;
            p6_neg2_reg <= n2[33] ^ sq_out_tag.den[32];
        end
    end

    // two dividers in lockstep for the plus and minus roots
    logic                dv1_vld, dv2_vld;
    logic [DIV_NW-1:0]   quo1, quo2;
    logic [DV_TAG_W-1:0] dv1_bits;
    logic                dv2_neg;
    dv_tag_t             dv1_tag;

    qrs_div_pipe #(
        .NUM_W (DIV_NW),
        .DEN_W (MAG_W),
        .TAG_W (DV_TAG_W)
    ) u_div_plus (
        .clk       (aclk),
        .rst_n     (aresetn),
        .en        (pipe_en),
        .in_valid  (p6_vld_reg),
        .num       ({p6_mag1_reg, {FRAC_BITS{1'b0}}}),
        .den       (p6_dmag_reg),
        .in_tag    (p6_tag_reg),
        .out_valid (dv1_vld),
        .quo       (quo1),
        .out_tag   (dv1_bits)
    );

    qrs_div_pipe #(
        .NUM_W (DIV_NW),
        .DEN_W (MAG_W),
        .TAG_W (1)
    ) u_div_minus (
        .clk       (aclk),
        .rst_n     (aresetn),
        .en        (pipe_en),
        .in_valid  (p6_vld_reg),
        .num       ({p6_mag2_reg, {FRAC_BITS{1'b0}}}),
        .den       (p6_dmag_reg),
        .in_tag    (p6_neg2_reg),
        .out_valid (dv2_vld),
        .quo       (quo2),
        .out_tag   (dv2_neg)
    );

    assign dv1_tag = dv1_bits;

    // output register: clip roots, mask unused ones, merge saturation
    logic          m_valid_reg;
    qrs_pkg::out_t m_data_reg;
    qrs_pkg::out_t m_data_next;
    logic [32:0]   clip1, clip2;

    always_comb begin
        clip1                   = clip_root(quo1, dv1_tag.neg);
        clip2                   = clip_root(quo2, dv2_neg);
        m_data_next.root_count  = dv1_tag.count;
        m_data_next.root_one    = dv1_tag.r1_zero ? 32'sd0 : clip1[31:0];
        m_data_next.root_two    = dv1_tag.two ? clip2[31:0] : 32'sd0;
        m_data_next.saturated   = dv1_tag.sat | (!dv1_tag.r1_zero & clip1[32])
                                | (dv1_tag.two & clip2[32]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= dv1_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            m_data_reg <= m_data_next;
        end
    end

    // the whole pipeline advances unless a finished result is held
    assign pipe_en = !m_valid_reg || m_ready;
    assign s_ready = pipe_en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `QRS_ASSERT_IMPLY(a_root_two_only_when_two, aclk, aresetn,
        m_valid && (m_data.root_count != qrs_pkg::CNT_TWO), m_data.root_two == 32'sd0,
        "root_two set without two roots")
    `QRS_ASSERT_IMPLY(a_root_one_zero_when_none, aclk, aresetn,
        m_valid && ((m_data.root_count == qrs_pkg::CNT_NONE)
            || (m_data.root_count == qrs_pkg::CNT_ALL)), m_data.root_one == 32'sd0,
        "root_one set without a root")
    `QRS_ASSERT_IMPLY(a_all_never_saturates, aclk, aresetn,
        m_valid && (m_data.root_count == qrs_pkg::CNT_ALL), !m_data.saturated,
        "saturation reported for the every-number case")
    `QRS_ASSERT_IMPLY(a_dividers_lockstep, aclk, aresetn,
        1'b1, dv1_vld == dv2_vld,
        "divider pipelines out of step")
    `QRS_ASSERT_NEXT(a_stall_holds_stage6, aclk, aresetn,
        !pipe_en && p6_vld_reg, p6_vld_reg && $stable(p6_dmag_reg),
        "stage 6 moved during a stall")

endmodule
